FILE: src/skgc_pkg.sv
// shared types and constants for the soft-knee gain computer
// no dependencies
package skgc_pkg;

    localparam logic [12:0] RATIO_ONE = 13'd256;
    localparam logic [12:0] RATIO_MIN = 13'd26;
    localparam logic [12:0] RATIO_MAX = 13'd5120;

    localparam int QBITS  = 17;
    localparam int NW     = 56;
    localparam int DW     = 40;
    localparam int QDEPTH = 2;

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_LIN  = 2'd1;
    localparam logic [1:0] MODE_CK   = 2'd2;
    localparam logic [1:0] MODE_EK   = 2'd3;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_RATIO     = 2'd1;
    localparam logic [1:0] CFG_KNEE      = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [16:0] dm;
        logic [15:0]        w;
        logic signed [13:0] rm;
        logic [12:0]        rc;
        logic [13:0]        k;
    } entry_t;

    typedef struct packed {
        logic          vld;
        logic          neg;
        logic [NW-1:0] num;
        logic [DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             vld;
        logic             neg;
        logic             ovf;
        logic [QBITS-1:0] q;
    } div_res_t;

endpackage

FILE: src/skgc_front.sv
// front end: configuration registers, request accept and curve region classify
// depends on skgc_pkg
module skgc_front
    import skgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] level_db,
    input  logic               queue_full,
    output logic               push,
    output entry_t             push_entry
);

    logic signed [15:0] thr_reg, thr_next;
    logic [12:0]        ratio_reg, ratio_next;
    logic [13:0]        knee_reg, knee_next;

    logic [12:0]        rc;
    logic signed [18:0] x2, t2, kx, ks2, ke2, u, v, dd;
    logic signed [16:0] dlin;
    logic               comp;
    logic [1:0]         mode;

    assign cfg_ready = 1'b1;
    assign busy      = queue_full;
    assign push      = start && !queue_full;

    always_comb
    begin
        thr_next   = thr_reg;
        ratio_next = ratio_reg;
        knee_next  = knee_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_next   = cfg_data;
                CFG_RATIO:     ratio_next = cfg_data[12:0];
                CFG_KNEE:      knee_next  = cfg_data[13:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= -16'sd5120;
            ratio_reg <= 13'd1024;
            knee_reg  <= 14'd0;
        end
        else
        begin
            thr_reg   <= thr_next;
            ratio_reg <= ratio_next;
            knee_reg  <= knee_next;
        end
    end

    always_comb
    begin
        if (ratio_reg < RATIO_MIN)
            rc = RATIO_MIN;
        else if (ratio_reg > RATIO_MAX)
            rc = RATIO_MAX;
        else
            rc = ratio_reg;
        comp = rc >= RATIO_ONE;
        x2   = {{2{level_db[15]}}, level_db, 1'b0};
        t2   = {{2{thr_reg[15]}}, thr_reg, 1'b0};
        kx   = {5'b0, knee_reg};
        ks2  = t2 - kx;
        ke2  = t2 + kx;
        u    = x2 - ks2;
        v    = ke2 - x2;
        dd   = t2 - x2;
        dlin = {thr_reg[15], thr_reg} - {level_db[15], level_db};

        mode = MODE_ZERO;
        if (comp)
        begin
            if (x2 > ke2)
                mode = MODE_LIN;
            else if (x2 >= ks2 && knee_reg != 14'd0)
                mode = MODE_CK;
        end
        else
        begin
            if (x2 < ks2)
                mode = MODE_LIN;
            else if (x2 <= ke2 && knee_reg != 14'd0)
                mode = MODE_EK;
        end

        push_entry.mode = mode;
        push_entry.dm   = (mode == MODE_LIN) ? dlin : dd[16:0];
        push_entry.w    = comp ? u[15:0] : v[15:0];
        push_entry.rm   = signed'({1'b0, rc} - {1'b0, RATIO_ONE});
        push_entry.rc   = rc;
        push_entry.k    = knee_reg;
    end

endmodule

FILE: src/skgc_queue.sv
// two-entry request queue between front and back end
// depends on skgc_pkg
module skgc_queue
    import skgc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   pop_valid,
    output entry_t pop_entry
);

    entry_t     mem_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = count_reg == 2'(QDEPTH);
    assign pop_valid = count_reg != 2'd0;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_valid ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop_valid);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/skgc_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow detect
// depends on skgc_pkg
module skgc_div
    import skgc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    logic [NW-1:0]    rem_reg [0:QBITS];
    logic [DW-1:0]    den_reg [0:QBITS];
    logic [QBITS-1:0] q_reg   [0:QBITS];
    logic             neg_reg [0:QBITS];
    logic             ovf_reg [0:QBITS];
    logic             vld_reg [0:QBITS];
    logic             ovf_next;

    assign ovf_next = (req.num >> QBITS) >= NW'(req.den);

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= req.num;
        den_reg[0] <= req.den;
        q_reg[0]   <= '0;
        neg_reg[0] <= req.neg;
        ovf_reg[0] <= ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= req.vld;
    end

    for (genvar j = 1; j <= QBITS; j++)
    begin : g_stage
        logic [NW:0] dsh;
        logic        ge;

        assign dsh = {1'b0, NW'(den_reg[j-1])} << (QBITS - j);
        assign ge  = {1'b0, rem_reg[j-1]} >= dsh;

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= ge ? rem_reg[j-1] - dsh[NW-1:0] : rem_reg[j-1];
            den_reg[j] <= den_reg[j-1];
            q_reg[j]   <= q_reg[j-1] | (QBITS'(ge) << (QBITS - j));
            neg_reg[j] <= neg_reg[j-1];
            ovf_reg[j] <= ovf_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else
                vld_reg[j] <= vld_reg[j-1];
        end
    end

    assign res.vld = vld_reg[QBITS];
    assign res.neg = neg_reg[QBITS];
    assign res.ovf = ovf_reg[QBITS];
    assign res.q   = q_reg[QBITS];

endmodule

FILE: src/skgc_back.sv
// back end: product stages, rounding offset, divider and saturating output
// depends on skgc_pkg and skgc_div
module skgc_back
    import skgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  entry_t             in_entry,
    output logic               result_valid,
    output logic signed [15:0] gain_change_db,
    output logic               saturated
);

    // stage 1
    logic               s1_vld_reg;
    logic [1:0]         s1_mode_reg;
    logic signed [33:0] s1_p1_reg, s1_p1_next;
    logic signed [30:0] s1_pd_reg, s1_pd_next;
    logic signed [30:0] s1_p2_reg, s1_p2_next;
    logic signed [13:0] s1_rm_reg;
    logic [12:0]        s1_rc_reg;
    logic [13:0]        s1_k_reg;
    logic signed [16:0] op_a, op_b, b2;
    logic signed [13:0] a2, nrm;

    // stage 2
    logic               s2_vld_reg;
    logic               s2_knee_reg;
    logic signed [NW:0] s2_prod_reg;
    logic [DW-1:0]      s2_den_reg, s2_den_next;
    logic signed [31:0] mb;
    logic signed [65:0] prod_full;
    logic [35:0]        ek_den;

    // stage 3
    div_req_t           s3_reg, s3_next;
    logic [NW-1:0]      mag;

    div_res_t           dres;
    logic               sat_next;
    logic signed [15:0] gain_next;
    logic               res_vld_reg;
    logic signed [15:0] gain_reg;
    logic               sat_reg;

    always_comb
    begin
        op_a = (in_entry.mode == MODE_LIN) ? in_entry.dm : signed'({1'b0, in_entry.w});
        op_b = (in_entry.mode == MODE_LIN) ? {{3{in_entry.rm[13]}}, in_entry.rm}
                                           : signed'({1'b0, in_entry.w});
        a2   = (in_entry.mode == MODE_CK) ? in_entry.rm : signed'({1'b0, in_entry.rc});
        b2   = (in_entry.mode == MODE_CK) ? signed'({1'b0, in_entry.w})
                                          : signed'({3'b0, in_entry.k});
        nrm  = -in_entry.rm;
        s1_p1_next = op_a * op_b;
        s1_pd_next = a2 * b2;
        s1_p2_next = in_entry.dm * nrm;
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg <= in_entry.mode;
        s1_p1_reg   <= s1_p1_next;
        s1_pd_reg   <= s1_pd_next;
        s1_p2_reg   <= s1_p2_next;
        s1_rm_reg   <= in_entry.rm;
        s1_rc_reg   <= in_entry.rc;
        s1_k_reg    <= in_entry.k;
    end

    always_comb
    begin
        case (s1_mode_reg)
            MODE_LIN: mb = 32'sd1;
            MODE_CK:  mb = {{18{s1_rm_reg[13]}}, s1_rm_reg};
            MODE_EK:  mb = {s1_p2_reg[30], s1_p2_reg};
            default:  mb = 32'sd0;
        endcase
        prod_full = s1_p1_reg * mb;
        ek_den    = 36'(s1_pd_reg[21:0]) * 36'(s1_k_reg);
        case (s1_mode_reg)
            MODE_LIN: s2_den_next = DW'(s1_rc_reg);
            MODE_CK:  s2_den_next = (DW'(s1_k_reg) << 10) + (DW'(s1_pd_reg[28:0]) << 1);
            MODE_EK:  s2_den_next = DW'(ek_den) << 3;
            default:  s2_den_next = DW'(1);
        endcase
    end

    always_ff @(posedge clk)
    begin
        s2_knee_reg <= (s1_mode_reg == MODE_CK) || (s1_mode_reg == MODE_EK);
        s2_prod_reg <= prod_full[NW:0];
        s2_den_reg  <= s2_den_next;
    end

    always_comb
    begin
        mag         = s2_prod_reg[NW] ? NW'(-s2_prod_reg) : NW'(s2_prod_reg);
        s3_next.vld = s2_vld_reg;
        s3_next.neg = s2_knee_reg ? (s2_prod_reg > 0) : s2_prod_reg[NW];
        s3_next.num = mag + NW'(s2_den_reg >> 1);
        s3_next.den = s2_den_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_reg     <= '0;
        end
        else
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_reg     <= s3_next;
        end
    end

    skgc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (s3_reg),
        .res   (dres)
    );

    always_comb
    begin
        if (dres.neg)
            sat_next = dres.ovf || (dres.q > QBITS'(32768));
        else
            sat_next = dres.ovf || (dres.q > QBITS'(32767));
        if (sat_next)
            gain_next = dres.neg ? -16'sd32768 : 16'sd32767;
        else
            gain_next = dres.neg ? 16'(-dres.q) : 16'(dres.q);
    end

    always_ff @(posedge clk)
    begin
        gain_reg <= gain_next;
        sat_reg  <= sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else
            res_vld_reg <= dres.vld;
    end

    assign result_valid   = res_vld_reg;
    assign gain_change_db = gain_reg;
    assign saturated      = sat_reg;

endmodule

FILE: src/soft_knee_gain_computer.sv
// top level of the soft-knee gain computer
// depends on skgc_pkg, skgc_front, skgc_queue and skgc_back
//
// One level in, one gain change out. A request is taken on any cycle with start
// high and busy low, and busy stays low in normal use, so a new level can enter
// every cycle. Its result appears on gain_change_db and saturated, flagged by
// result_valid for one cycle, after passing the two-entry queue, the product
// stages, the rounding stage, the 17-stage pipelined divider and the output
// register. The result cannot be held off, so the receiver must take it in that
// cycle. Configuration writes are always ready and apply to requests taken later.
module soft_knee_gain_computer
    import skgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] level_db,
    output logic               result_valid,
    output logic signed [15:0] gain_change_db,
    output logic               saturated
);

    localparam int LATENCY = QBITS + 6;

    logic   queue_full;
    logic   push;
    entry_t push_entry;
    logic   pop_valid;
    entry_t pop_entry;

    skgc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .level_db   (level_db),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    skgc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    skgc_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (pop_valid),
        .in_entry       (pop_entry),
        .result_valid   (result_valid),
        .gain_change_db (gain_change_db),
        .saturated      (saturated)
    );

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("request queue filled up");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |-> gain_change_db == 16'sh7fff || gain_change_db == 16'sh8000)
        else $error("saturated result not at a limit");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY result_valid)
        else $error("result missing after request");

endmodule

FILE: tb/soft_knee_gain_checker.sv
// checker for the soft-knee gain computer: watches the level and config channels,
// predicts each gain change and compares it with the block's result
// depends on skgc_pkg
`timescale 1ns / 1ps

module soft_knee_gain_checker
    import skgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] level_db,
    input  logic               result_valid,
    input  logic signed [15:0] gain_change_db,
    input  logic               saturated,
    output int                 fail_count,
    output int                 pending_gains,
    output int                 gains_checked
);

    typedef struct {
        logic signed [15:0] gain;
        logic               sat;
    } gain_t;

    gain_t              expected_gains[$];
    logic signed [15:0] thr;
    logic [12:0]        ratio;
    logic [13:0]        knee;

    function automatic longint round_div(longint n, longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic gain_t predict_gain(logic signed [15:0] lvl);
        longint x, t, k, r, x2, ks2, ke2, u, v, dd, den, g;
        gain_t res;
        x = lvl;
        t = thr;
        k = knee;
        r = ratio;
        if (r < RATIO_MIN)
            r = RATIO_MIN;
        if (r > RATIO_MAX)
            r = RATIO_MAX;
        x2 = 2 * x;
        ks2 = 2 * t - k;
        ke2 = 2 * t + k;
        g = 0;
        if (r >= RATIO_ONE)
        begin
            if (x2 > ke2)
                g = round_div((x - t) * (RATIO_ONE - r), r);
            else if (x2 >= ks2)
            begin
                u = x2 - ks2;
                den = 2 * (2 * RATIO_ONE * k + (r - RATIO_ONE) * u);
                if (den > 0)
                    g = round_div(-(u * u * (r - RATIO_ONE)), den);
            end
        end
        else
        begin
            if (x2 < ks2)
                g = round_div((t - x) * (r - RATIO_ONE), r);
            else if (x2 <= ke2)
            begin
                v = ke2 - x2;
                dd = 2 * t - x2;
                den = 8 * r * k * k;
                if (den > 0)
                    g = round_div(-(dd * (RATIO_ONE - r) * v * v), den);
            end
        end
        res.sat = 1'b0;
        if (g > 32767)
        begin
            g = 32767;
            res.sat = 1'b1;
        end
        else if (g < -32768)
        begin
            g = -32768;
            res.sat = 1'b1;
        end
        res.gain = 16'(g);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gain_t want;
        int    errs;
        if (!rst_n)
        begin
            thr <= -16'sd5120;
            ratio <= 13'd1024;
            knee <= 14'd0;
            expected_gains.delete();
            fail_count <= 0;
            gains_checked <= 0;
        end
        else
        begin
            errs = 0;
            if (start && !busy)
                expected_gains.push_back(predict_gain(level_db));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_THRESHOLD: thr <= cfg_data;
                    CFG_RATIO: ratio <= cfg_data[12:0];
                    CFG_KNEE: knee <= cfg_data[13:0];
                    default: ;
                endcase
            end
            if (result_valid)
            begin
                if (expected_gains.size() == 0)
                begin
                    $error("result with no request waiting: gain %0d", gain_change_db);
                    errs++;
                end
                else
                begin
                    want = expected_gains.pop_front();
                    gains_checked <= gains_checked + 1;
                    if (gain_change_db !== want.gain)
                    begin
                        $error("gain_change_db: expected %0d, actual %0d",
                               want.gain, gain_change_db);
                        errs++;
                    end
                    if (saturated !== want.sat)
                    begin
                        $error("saturated: expected %0d, actual %0d", want.sat, saturated);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

    assign pending_gains = expected_gains.size();

endmodule

FILE: tb/soft_knee_gain_computer_tb.sv
// testbench top for the soft-knee gain computer: drives levels and config writes
// through several register settings and idle patterns, then gives the verdict
// depends on skgc_pkg, soft_knee_gain_checker and the block
`timescale 1ns / 1ps

module soft_knee_gain_computer_tb;
    import skgc_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = CFG_THRESHOLD;
    logic [15:0]        cfg_data = '0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] level_db = '0;
    logic               result_valid;
    logic signed [15:0] gain_change_db;
    logic               saturated;
    int                 fail_count, pending_gains, gains_checked;
    int                 idle_pct;
    int                 sent;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    soft_knee_gain_computer dut (.*);

    soft_knee_gain_checker checker_i (.*);

    task automatic send_level(logic signed [15:0] lvl);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        level_db <= lvl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_gains != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_curve(logic [15:0] t, logic [15:0] r, logic [15:0] k);
        drain();
        write_reg(CFG_THRESHOLD, t);
        write_reg(CFG_RATIO, r);
        write_reg(CFG_KNEE, k);
        @(posedge clk);
    endtask

    // mostly levels near the threshold and knee, some anywhere
    function automatic logic signed [15:0] pick_level(logic signed [15:0] t, int k);
        int sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return 16'($urandom);
        else if (sel < 8)
            return t + 16'($signed($urandom_range(2 * k + 64)) - k - 32);
        return t + 16'($signed($urandom_range(8)) - 4);
    endfunction

    initial
    begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [15:0] t, r, k;
        sent = 0;
        idle_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset curve, then hard and soft knees, both modes, extremes
        send_level(16'sh7FFF);
        send_level(-16'sh8000);
        send_level(-16'sd5120);
        send_level(-16'sd5119);
        send_level(16'sd0);
        set_curve(16'h8000, 16'd5120, 16'd12288);
        send_level(16'sh7FFF);
        send_level(-16'sh8000);
        set_curve(16'h7FFF, 16'd0, 16'd0);
        send_level(-16'sh8000);
        send_level(16'sh7FFF);
        send_level(16'sh7FFE);
        set_curve(16'h0000, 16'h1FFF, 16'h3FFF);
        send_level(16'sh7FFF);
        send_level(16'sd0);
        send_level(-16'sd8192);
        set_curve(16'h0000, 16'd128, 16'd1);
        send_level(16'sd0);
        send_level(16'sd1);
        send_level(-16'sd1);
        send_level(-16'sh8000);
        set_curve(16'hF000, 16'd256, 16'd3000);
        send_level(16'shF000);
        send_level(16'sh7FFF);
        send_level(-16'sh8000);

        // receiver cannot stall, so half the phases run the sender flat out
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 52;
                2: idle_pct = 7;
                default: idle_pct = 0;
            endcase
            t = 16'($urandom);
            if (ph % 3 == 0)
                t = 16'($signed($urandom_range(4000)) - 2000);
            case (ph % 5)
                0: r = 16'($urandom_range(255, 26));
                1: r = 16'($urandom_range(5120, 256));
                2: r = 16'($urandom_range(25));
                3: r = 16'($urandom_range(8191, 5121));
                default: r = 16'($urandom);
            endcase
            k = (ph % 4 == 3) ? 16'd0 : 16'($urandom_range(12288));
            if (ph == 5)
                k = 16'h3FFF;
            set_curve(t, r, k);
            repeat (97)
                send_level(pick_level(t, k[13:0]));
        end
        drain();
        $display("%0d levels sent over 22 curve settings, %0d gains checked",
                 sent, gains_checked);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
